### rtl/core/cc2p_pkg.sv
// Package holding the types, widths and constants of the Cartesian-to-polar CORDIC.
`timescale 1ns / 1ps
package cc2p_pkg;

  localparam int DATA_W   = 16;
  localparam int ANGLE_W  = 16;
  localparam int INT_W    = DATA_W + 2;
  localparam int MAX_ITER = 16;
  localparam int GAIN_W   = 17;
  localparam int GAIN_FRAC = 16;
  localparam int PROD_W   = INT_W + GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_Q16 = GAIN_W'(39796);
  localparam logic signed [ANGLE_W-1:0] HALF_PI = ANGLE_W'(12867);

  localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [MAX_ITER] = '{
    ANGLE_W'(6433), ANGLE_W'(3798), ANGLE_W'(2006), ANGLE_W'(1018),
    ANGLE_W'(511),  ANGLE_W'(255),  ANGLE_W'(127),  ANGLE_W'(63),
    ANGLE_W'(31),   ANGLE_W'(15),   ANGLE_W'(7),    ANGLE_W'(3),
    ANGLE_W'(1),    ANGLE_W'(0),    ANGLE_W'(0),    ANGLE_W'(0)
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] x_coord;
    logic signed [DATA_W-1:0] y_coord;
  } cc2p_in_t;

  typedef struct packed {
    logic        [DATA_W-1:0]  radius;
    logic signed [ANGLE_W-1:0] angle;
  } cc2p_out_t;

  typedef struct packed {
    logic signed [INT_W-1:0]   x;
    logic signed [INT_W-1:0]   y;
    logic signed [ANGLE_W-1:0] z;
  } cc2p_vec_t;

endpackage

### rtl/core/cordic_cartesian_to_polar.sv
// Top level: CORDIC vectoring chain from (x, y) to (radius, angle).
// Throughput: one beat per cycle while in_stall is low; every cell of the chain advances in each such cycle.
// A skid register behind the output register holds one beat while out_stall is high;
// the chain freezes only while that skid register is full.
// Reset: synchronous active-low rst_n clears all valid bits and the skid flag.
`timescale 1ns / 1ps
module cordic_cartesian_to_polar import cc2p_pkg::*; #(
  parameter int ITERATIONS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cc2p_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cc2p_out_t out_data
);

  logic      stg_v [ITERATIONS+1];
  cc2p_vec_t stg_d [ITERATIONS+1];

  logic      tail_v;
  cc2p_out_t tail_d;
  logic      en;

  logic      out_valid_r;
  cc2p_out_t out_data_r;
  logic      skid_full_r;
  cc2p_out_t skid_r;

  assign en = !skid_full_r;

  cc2p_prerot u_prerot (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid && !in_stall),
    .in_d  (in_data),
    .out_v (stg_v[0]),
    .out_d (stg_d[0])
  );

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    cc2p_cell #(.STAGE(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (stg_v[k]),
      .in_d  (stg_d[k]),
      .out_v (stg_v[k+1]),
      .out_d (stg_d[k+1])
    );
  end

  cc2p_gain u_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (stg_v[ITERATIONS]),
    .in_d  (stg_d[ITERATIONS]),
    .out_v (tail_v),
    .out_d (tail_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_valid_r && out_stall) begin
      if (tail_v && en) begin
        skid_full_r <= 1'b1;
      end
    end else if (skid_full_r) begin
      out_valid_r <= 1'b1;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= tail_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_stall) begin
      if (tail_v && en) begin
        skid_r <= tail_d;
      end
    end else if (skid_full_r) begin
      out_data_r <= skid_r;
    end else begin
      out_data_r <= tail_d;
    end
  end

  assign in_stall  = skid_full_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/cc2p_prerot.sv
// Entry cell: quarter-turn pre-rotation and angle seed.
`timescale 1ns / 1ps
module cc2p_prerot import cc2p_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_v,
  input  cc2p_in_t  in_d,
  output logic      out_v,
  output cc2p_vec_t out_d
);

  logic      v_r;
  cc2p_vec_t d_r;
  cc2p_vec_t d_nxt;
  logic signed [INT_W-1:0] xe;
  logic signed [INT_W-1:0] ye;

  assign xe = INT_W'(in_d.x_coord);
  assign ye = INT_W'(in_d.y_coord);

  always_comb begin
    if (!in_d.y_coord[DATA_W-1]) begin
      d_nxt.x = ye;
      d_nxt.y = -xe;
      d_nxt.z = HALF_PI;
    end else begin
      d_nxt.x = -ye;
      d_nxt.y = xe;
      d_nxt.z = -HALF_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

### rtl/core/cc2p_cell.sv
// One CORDIC micro-rotation cell of the vectoring chain.
`timescale 1ns / 1ps
module cc2p_cell import cc2p_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_v,
  input  cc2p_vec_t in_d,
  output logic      out_v,
  output cc2p_vec_t out_d
);

  localparam logic signed [ANGLE_W-1:0] ATAN = ATAN_TABLE[STAGE];

  logic      v_r;
  cc2p_vec_t d_r;
  cc2p_vec_t d_nxt;
  logic signed [INT_W-1:0] sx;
  logic signed [INT_W-1:0] sy;

  assign sx = in_d.x >>> STAGE;
  assign sy = in_d.y >>> STAGE;

  always_comb begin
    if (!in_d.y[INT_W-1]) begin
      d_nxt.x = in_d.x + sy;
      d_nxt.y = in_d.y - sx;
      d_nxt.z = in_d.z + ATAN;
    end else begin
      d_nxt.x = in_d.x - sy;
      d_nxt.y = in_d.y + sx;
      d_nxt.z = in_d.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

### rtl/core/cc2p_gain.sv
// Exit cell: gain multiply, then radius clamp to the unsigned output range.
`timescale 1ns / 1ps
module cc2p_gain import cc2p_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_v,
  input  cc2p_vec_t in_d,
  output logic      out_v,
  output cc2p_out_t out_d
);

  localparam logic signed [PROD_W-1:0] GAIN_S = PROD_W'(GAIN_Q16);

  logic                     v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [ANGLE_W-1:0]       z_r;

  assign prod_nxt = PROD_W'(in_d.x) * GAIN_S;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      z_r    <= in_d.z;
    end
  end

  always_comb begin
    priority if (prod_r[PROD_W-1]) begin
      out_d.radius = '0;
    end else if (|prod_r[PROD_W-2:GAIN_FRAC+DATA_W]) begin
      out_d.radius = '1;
    end else begin
      out_d.radius = prod_r[GAIN_FRAC+DATA_W-1:GAIN_FRAC];
    end
    out_d.angle = z_r;
  end

  assign out_v = v_r;

endmodule

### rtl/core/cc2p_checker.sv
// Port-level checker for the Cartesian-to-polar CORDIC, bound to the top level.
`timescale 1ns / 1ps
module cc2p_checker import cc2p_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input cc2p_out_t out_data
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stall set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_stall_needs_held_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no output beat pending");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall raised without a stalled output beat");

  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || !out_stall |=> !in_stall)
    else $error("input stall held after output drained");

endmodule

bind cordic_cartesian_to_polar cc2p_checker u_cc2p_checker (.*);

### test/cordic_cartesian_to_polar_tb.sv
// Testbench for the Cartesian-to-polar CORDIC: random and corner points against a predictor.
`timescale 1ns / 1ps
module cordic_cartesian_to_polar_tb;
  import cc2p_pkg::*;

  localparam int  STEPS      = 16;
  localparam int  RAW_FRAC   = 30;
  localparam int  ANG_FRAC   = ANGLE_W - 3;
  localparam longint HALF_PI_RAW = 64'd1686629362;
  localparam longint GAIN_RAW    = 64'd39796;
  localparam int  ANG_MAX    = (1 << (ANGLE_W - 1)) - 1;
  localparam int  ANG_MIN    = -(1 << (ANGLE_W - 1));
  localparam longint RAD_MAX = (64'd1 << DATA_W) - 1;
  localparam int  RAND_PER_PHASE = 282;
  localparam int  PHASES     = 4;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  CYCLE_LIMIT  = 400000;

  typedef struct packed {
    cc2p_in_t  pt;
    cc2p_out_t res;
  } polar_exp_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  cc2p_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  cc2p_out_t out_data;

  longint atan_raw [STEPS] = '{
    64'd843300722, 64'd497829485, 64'd263039428, 64'd133522920,
    64'd67020564,  64'd33542954,  64'd16775570,  64'd8388297,
    64'd4194213,   64'd2097114,   64'd1048558,   64'd524279,
    64'd262140,    64'd131070,    64'd65535,     64'd32767
  };

  cc2p_in_t   point_q [$];
  polar_exp_t polar_q [$];
  int         idle_pct;
  int         stall_pct;
  logic       in_taken;
  int         n_errors;
  int         n_sent;
  int         n_checked;
  int         cycle_cnt;

  cordic_cartesian_to_polar u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic cc2p_out_t polar_of(cc2p_in_t pt);
    logic signed [INT_W-1:0] px;
    logic signed [INT_W-1:0] py;
    logic signed [INT_W-1:0] vx;
    logic signed [INT_W-1:0] vy;
    logic signed [INT_W-1:0] sx;
    logic signed [INT_W-1:0] sy;
    int        acc;
    int        step_ang;
    longint    prod;
    cc2p_out_t res;
    px = pt.x_coord;
    py = pt.y_coord;
    if (py >= 0) begin
      vx  = py;
      vy  = -px;
      acc = int'(HALF_PI_RAW >>> (RAW_FRAC - ANG_FRAC));
    end else begin
      vx  = -py;
      vy  = px;
      acc = -int'(HALF_PI_RAW >>> (RAW_FRAC - ANG_FRAC));
    end
    for (int j = 0; j < STEPS; j++) begin
      sx = vx >>> j;
      sy = vy >>> j;
      step_ang = int'(atan_raw[j] >>> (RAW_FRAC - ANG_FRAC));
      if (vy >= 0) begin
        vx  = vx + sy;
        vy  = vy - sx;
        acc = acc + step_ang;
      end else begin
        vx  = vx - sy;
        vy  = vy + sx;
        acc = acc - step_ang;
      end
      if (acc > ANG_MAX) acc = ANG_MAX;
      if (acc < ANG_MIN) acc = ANG_MIN;
    end
    prod = (longint'(vx) * GAIN_RAW) >>> 16;
    if (prod < 0) prod = 0;
    if (prod > RAD_MAX) prod = RAD_MAX;
    res.radius = prod[DATA_W-1:0];
    res.angle  = acc[ANGLE_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic push_point(input int x, input int y);
    cc2p_in_t pt;
    pt.x_coord = x[DATA_W-1:0];
    pt.y_coord = y[DATA_W-1:0];
    point_q.push_back(pt);
  endtask

  // drive input beats and output stalls on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!in_valid || in_taken) begin
        if (point_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= point_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // sample both channels on the rising edge
  always @(posedge clk) begin
    polar_exp_t e;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (polar_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result radius=%0d angle=%0d",
                                  out_data.radius, out_data.angle));
      end else begin
        e = polar_q.pop_front();
        n_checked++;
        if (out_data.radius !== e.res.radius)
          report_mismatch($sformatf("x=%0d y=%0d radius got %0d exp %0d",
                                    e.pt.x_coord, e.pt.y_coord,
                                    out_data.radius, e.res.radius));
        if (out_data.angle !== e.res.angle)
          report_mismatch($sformatf("x=%0d y=%0d angle got %0d exp %0d",
                                    e.pt.x_coord, e.pt.y_coord,
                                    out_data.angle, e.res.angle));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      e.pt  = in_data;
      e.res = polar_of(in_data);
      polar_q.push_back(e);
      n_sent++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("cordic_cartesian_to_polar test failed");
      $finish;
    end
  end

  initial begin
    int sel;
    int x;
    int y;
    int corner [7];
    corner = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    in_taken  = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    n_errors  = 0;
    n_sent    = 0;
    n_checked = 0;
    cycle_cnt = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    push_point(0, 0);
    push_point(32767, 0);
    push_point(-32768, 0);
    push_point(0, 32767);
    push_point(0, -32768);
    push_point(32767, 32767);
    push_point(-32768, -32768);
    push_point(-32768, 32767);
    push_point(32767, -32768);
    push_point(1, 0);
    push_point(0, 1);
    push_point(-1, 0);
    push_point(0, -1);
    push_point(-1, -1);
    push_point(4096, 4096);
    push_point(4096, 0);
    push_point(-4096, 0);
    push_point(0, 4096);
    push_point(-4096, -1);
    push_point(4096, -1);
    push_point(-32768, -1);
    push_point(-1, -32768);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        sel = $urandom_range(9);
        x = $signed(16'($urandom));
        y = $signed(16'($urandom));
        case (sel)
          5: begin
            x = $urandom_range(64) - 32;
            y = $urandom_range(64) - 32;
          end
          6: if ($urandom_range(1)) x = 0; else y = 0;
          7: begin
            x = corner[$urandom_range(6)];
            y = corner[$urandom_range(6)];
          end
          8: y = -$urandom_range(1);
          9: y = $urandom_range(1) ? x : -x;
          default: ;
        endcase
        if (y > 32767) y = 32767;
        push_point(x, y);
      end
      while (point_q.size() != 0 || in_valid || polar_q.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d points over %0d handshake phases, checked %0d polar results.",
             n_sent, PHASES, n_checked);
    $display("Covered axis, quadrant, corner and origin points with random idles and stalls.");
    if (n_errors == 0 && polar_q.size() == 0) begin
      $display("cordic_cartesian_to_polar test passed");
    end else begin
      $display("cordic_cartesian_to_polar test failed");
    end
    $finish;
  end

endmodule
